### rtl/core/tmce_pkg.sv
package tmce_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   localparam int KIND_W = 2;
   localparam int CHAR_W = 8;
   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int POS_W = 11;
   localparam int COLOR_W = 4;
   localparam int TAB_W = 5;
   localparam int CELL_W = 2 * CHAR_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_PUT          = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR_SCREEN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR_LINE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ         = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h00;
   localparam logic [CHAR_W-1:0] RESET_ATTR     = 8'h0F;

   localparam logic [1:0] REG_FG_COLOR = 2'd0;
   localparam logic [1:0] REG_BG_COLOR = 2'd1;
   localparam logic [1:0] REG_TAB_SIZE = 2'd2;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
   localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;

   typedef enum logic [3:0] {
      OP_PRINT,
      OP_NEWLINE,
      OP_TAB,
      OP_RETURN,
      OP_BACKSPACE,
      OP_CLEAR_ALL,
      OP_CLEAR_LINE,
      OP_READ,
      OP_READ_NONE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [COL_W-1:0]    read_col;
      logic [ROW_W-1:0]    read_row;
   } item_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             scroll;
   } cursor_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_TAB_DIV,
      ST_TAB_PUT,
      ST_SWEEP,
      ST_READ_WAIT,
      ST_DONE
   } back_state_type;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] vis,
                                                 input logic [ROW_W-1:0] top);
      logic [ROW_W:0] s;
      s = {1'b0, vis} + {1'b0, top};
      if (s >= (ROW_W+1)'(ROWS)) begin
         s = s - (ROW_W+1)'(ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
   endfunction

   function automatic cursor_type settle(input logic [COL_W-1:0] col_a,
                                         input logic [ROW_W-1:0] row_a);
      cursor_type c;
      c.col = col_a;
      c.row = row_a;
      c.scroll = 1'b0;
      if (c.col >= COL_W'(COLUMNS)) begin
         c.col = '0;
         c.row = c.row + 1'b1;
      end
      if (c.row >= ROW_W'(ROWS)) begin
         c.row = ROW_W'(ROWS - 1);
         c.scroll = 1'b1;
      end
      return c;
   endfunction

endpackage

### rtl/core/text_mode_console_engine_unit.sv
// Text-mode console engine with an 80x25 cell store and a cursor.
// Request beats (req_*) carry one command: put character, clear screen,
// clear the cursor's line, or read one cell. Every request yields exactly
// one response beat (rsp_*) with the cursor after the command and, for a
// read, the cell's character and attribute. Colors and tab spacing are
// set through the APB-style register port; the user must write them only
// while the engine is idle, which the block itself leaves unenforced.
// Requests are classified on entry and held in a two-entry queue; the
// execution side works on one command at a time against the cell memory.
// The memory write port writes one cell per cycle, so a tab writes its
// spaces one by one after a bit-serial division finds the next stop, and a
// scroll, a clear line or a clear screen sweeps its cells one by one.
// A plain command passes through a done state that loads the response, so
// the execution side takes the next character only after the last one ends.
// After reset the engine writes every cell to char 0 with attribute 0x0F
// and holds req_ready low meanwhile.
// A stalled response stays in the output register; the queue keeps taking
// requests until it is full.
module text_mode_console_engine_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tmce_pkg::KIND_W-1:0]      req_kind,
   input  logic [tmce_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tmce_pkg::COL_W-1:0]       req_read_col,
   input  logic [tmce_pkg::ROW_W-1:0]       req_read_row,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tmce_pkg::COL_W-1:0]       rsp_cursor_col,
   output logic [tmce_pkg::ROW_W-1:0]       rsp_cursor_row,
   output logic [tmce_pkg::POS_W-1:0]       rsp_cursor_position,
   output logic [tmce_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic [tmce_pkg::CHAR_W-1:0]      rsp_cell_attr,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tmce_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tmce_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tmce_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import tmce_pkg::*;

   logic [COLOR_W-1:0] fg_ff;
   logic [COLOR_W-1:0] bg_ff;
   logic [TAB_W-1:0]   tab_ff;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic               init_busy;
   logic               push_valid, push_ready;
   item_type           push_item;
   logic               pop_valid, pop_ready;
   item_type           pop_item;

   assign pready = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
         tab_ff <= TAB_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_FG_COLOR: fg_ff <= pwdata[COLOR_W-1:0];
            REG_BG_COLOR: bg_ff <= pwdata[COLOR_W-1:0];
            REG_TAB_SIZE: tab_ff <= pwdata[TAB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FG_COLOR: prdata = CSR_DATA_W'(fg_ff);
         REG_BG_COLOR: prdata = CSR_DATA_W'(bg_ff);
         REG_TAB_SIZE: prdata = CSR_DATA_W'(tab_ff);
         default:      prdata = '0;
      endcase
   end

   tmce_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_char_code (req_char_code),
      .req_read_col  (req_read_col),
      .req_read_row  (req_read_row),
      .init_busy     (init_busy),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   tmce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tmce_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_item            (pop_item),
      .fg_color            (fg_ff),
      .bg_color            (bg_ff),
      .tab_size            (tab_ff),
      .init_busy           (init_busy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_char       (rsp_cell_char),
      .rsp_cell_attr       (rsp_cell_attr)
   );

endmodule

### rtl/core/tmce_front.sv
module tmce_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tmce_pkg::KIND_W-1:0]   req_kind,
   input  logic [tmce_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tmce_pkg::COL_W-1:0]    req_read_col,
   input  logic [tmce_pkg::ROW_W-1:0]    req_read_row,
   input  logic                          init_busy,
   output logic                          push_valid,
   input  logic                          push_ready,
   output tmce_pkg::item_type            push_item
);
   import tmce_pkg::*;

   op_type op;

   always_comb begin
      case (req_kind)
         KIND_PUT: begin
            case (req_char_code)
               CHAR_NEWLINE:   op = OP_NEWLINE;
               CHAR_TAB:       op = OP_TAB;
               CHAR_RETURN:    op = OP_RETURN;
               CHAR_BACKSPACE: op = OP_BACKSPACE;
               default:        op = OP_PRINT;
            endcase
         end
         KIND_CLEAR_SCREEN: op = OP_CLEAR_ALL;
         KIND_CLEAR_LINE:   op = OP_CLEAR_LINE;
         KIND_READ: begin
            if (req_read_col < COL_W'(COLUMNS) && req_read_row < ROW_W'(ROWS)) begin
               op = OP_READ;
            end else begin
               op = OP_READ_NONE;
            end
         end
         default: op = OP_READ_NONE;
      endcase
   end

   assign req_ready = push_ready & ~init_busy;
   assign push_valid = req_valid & ~init_busy;
   assign push_item = '{op: op, char_code: req_char_code,
                        read_col: req_read_col, read_row: req_read_row};

endmodule

### rtl/core/tmce_queue.sv
module tmce_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tmce_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tmce_pkg::item_type pop_item
);
   import tmce_pkg::*;

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push = push_valid & push_ready;
   assign do_pop = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/tmce_back.sv
module tmce_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  tmce_pkg::item_type             pop_item,
   input  logic [tmce_pkg::COLOR_W-1:0]   fg_color,
   input  logic [tmce_pkg::COLOR_W-1:0]   bg_color,
   input  logic [tmce_pkg::TAB_W-1:0]     tab_size,
   output logic                           init_busy,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tmce_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tmce_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tmce_pkg::POS_W-1:0]     rsp_cursor_position,
   output logic [tmce_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [tmce_pkg::CHAR_W-1:0]    rsp_cell_attr
);
   import tmce_pkg::*;

   back_state_type    state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_last_ff, sweep_last_in;
   logic [CELL_W-1:0] sweep_data_ff, sweep_data_in;
   logic              tab_more_ff, tab_more_in;
   logic [TAB_W-1:0]  ts_ff, ts_in;
   logic [TAB_W-1:0]  rem_ff, rem_in;
   logic [2:0]        step_ff, step_in;
   logic [TAB_W-1:0]  tab_left_ff, tab_left_in;
   logic              read_ok_ff, read_ok_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [CELL_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;

   logic [CELL_W-1:0] mem [CELLS];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] rd_addr;

   logic [CHAR_W-1:0] attr;
   logic [ROW_W-1:0]  cur_phys;
   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] top_base;
   logic [ROW_W-1:0]  next_top;
   cursor_type        put_cur;
   cursor_type        nl_cur;
   logic [TAB_W:0]    rem_sh;
   logic [TAB_W-1:0]  rem_nx;
   logic              rsp_load;
   logic              sweep_end;

   assign attr = {bg_color, fg_color};
   assign cur_phys = phys_row(line_ff, top_ff);
   assign cur_addr = cell_addr(cur_phys, col_ff);
   assign top_base = cell_addr(top_ff, '0);
   assign next_top = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
   assign put_cur = settle(col_ff + 1'b1, line_ff);
   assign nl_cur = settle('0, line_ff + 1'b1);
   assign rem_sh = {rem_ff, col_ff[step_ff]};
   assign rem_nx = (rem_sh >= {1'b0, ts_ff}) ? TAB_W'(rem_sh - {1'b0, ts_ff})
                                             : rem_sh[TAB_W-1:0];
   assign rsp_load = !rsp_valid_ff || rsp_ready;
   assign sweep_end = sweep_addr_ff == sweep_last_ff;

   assign init_busy = state_ff == ST_INIT;
   assign pop_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sweep_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_item.op)
                  OP_PRINT:      state_in = put_cur.scroll ? ST_SWEEP : ST_DONE;
                  OP_NEWLINE:    state_in = nl_cur.scroll ? ST_SWEEP : ST_DONE;
                  OP_TAB:        state_in = ST_TAB_DIV;
                  OP_CLEAR_ALL:  state_in = ST_SWEEP;
                  OP_CLEAR_LINE: state_in = ST_SWEEP;
                  OP_READ:       state_in = ST_READ_WAIT;
                  OP_READ_NONE:  state_in = ST_READ_WAIT;
                  default:       state_in = ST_DONE;
               endcase
            end
         end
         ST_TAB_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_TAB_PUT;
            end
         end
         ST_TAB_PUT: begin
            if (put_cur.scroll) begin
               state_in = ST_SWEEP;
            end else if (tab_left_ff == TAB_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_SWEEP: begin
            if (sweep_end) begin
               state_in = tab_more_ff ? ST_TAB_PUT : ST_DONE;
            end
         end
         ST_READ_WAIT: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      col_in = col_ff;
      line_in = line_ff;
      top_in = top_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      sweep_data_in = sweep_data_ff;
      tab_more_in = tab_more_ff;
      ts_in = ts_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      tab_left_in = tab_left_ff;
      read_ok_in = read_ok_ff;
      cell_in = cell_ff;
      rsp_col_in = rsp_col_ff;
      rsp_row_in = rsp_row_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_cell_in = rsp_cell_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mem_we = 1'b0;
      mem_addr = cur_addr;
      mem_wdata = {attr, CHAR_BLANK};
      rd_addr = cell_addr(phys_row(pop_item.read_row, top_ff), pop_item.read_col);
      case (state_ff)
         ST_INIT, ST_SWEEP: begin
            mem_we = 1'b1;
            mem_addr = sweep_addr_ff;
            mem_wdata = sweep_data_ff;
            sweep_addr_in = sweep_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (pop_valid) begin
               cell_in = '0;
               tab_more_in = 1'b0;
               sweep_addr_in = top_base;
               sweep_last_in = top_base + ADDR_W'(COLUMNS - 1);
               sweep_data_in = {attr, CHAR_BLANK};
               case (pop_item.op)
                  OP_PRINT: begin
                     mem_we = 1'b1;
                     mem_wdata = {attr, pop_item.char_code};
                     col_in = put_cur.col;
                     line_in = put_cur.row;
                     if (put_cur.scroll) begin
                        top_in = next_top;
                     end
                  end
                  OP_NEWLINE: begin
                     col_in = nl_cur.col;
                     line_in = nl_cur.row;
                     if (nl_cur.scroll) begin
                        top_in = next_top;
                     end
                  end
                  OP_TAB: begin
                     ts_in = (tab_size == '0) ? TAB_W'(1) : tab_size;
                     rem_in = '0;
                     step_in = 3'(COL_W - 1);
                  end
                  OP_RETURN: col_in = '0;
                  OP_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                        mem_we = 1'b1;
                        mem_addr = cell_addr(cur_phys, col_ff - 1'b1);
                     end
                  end
                  OP_CLEAR_ALL: begin
                     sweep_addr_in = '0;
                     sweep_last_in = ADDR_W'(CELLS - 1);
                     top_in = '0;
                     col_in = '0;
                     line_in = '0;
                  end
                  OP_CLEAR_LINE: begin
                     sweep_addr_in = cell_addr(cur_phys, '0);
                     sweep_last_in = cell_addr(cur_phys, COL_W'(COLUMNS - 1));
                     col_in = '0;
                  end
                  OP_READ: read_ok_in = 1'b1;
                  OP_READ_NONE: read_ok_in = 1'b0;
                  default: ;
               endcase
            end
         end
         ST_TAB_DIV: begin
            rem_in = rem_nx;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               tab_left_in = ts_ff - rem_nx;
            end
         end
         ST_TAB_PUT: begin
            mem_we = 1'b1;
            mem_wdata = {attr, CHAR_SPACE};
            col_in = put_cur.col;
            line_in = put_cur.row;
            tab_left_in = tab_left_ff - 1'b1;
            if (put_cur.scroll) begin
               top_in = next_top;
               sweep_addr_in = top_base;
               sweep_last_in = top_base + ADDR_W'(COLUMNS - 1);
               sweep_data_in = {attr, CHAR_BLANK};
               tab_more_in = tab_left_ff != TAB_W'(1);
            end
         end
         ST_READ_WAIT: cell_in = read_ok_ff ? rd_data_ff : '0;
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_col_in = col_ff;
               rsp_row_in = line_ff;
               rsp_pos_in = POS_W'(cell_addr(line_ff, col_ff));
               rsp_cell_in = cell_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         col_ff <= '0;
         line_ff <= '0;
         top_ff <= '0;
         sweep_addr_ff <= '0;
         sweep_last_ff <= ADDR_W'(CELLS - 1);
         sweep_data_ff <= {RESET_ATTR, CHAR_BLANK};
         tab_more_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         line_ff <= line_in;
         top_ff <= top_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         sweep_data_ff <= sweep_data_in;
         tab_more_ff <= tab_more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff <= ts_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      tab_left_ff <= tab_left_in;
      read_ok_ff <= read_ok_in;
      cell_ff <= cell_in;
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_char = rsp_cell_ff[CHAR_W-1:0];
   assign rsp_cell_attr = rsp_cell_ff[CELL_W-1:CHAR_W];

endmodule
